// File: sv/pstp_pkg.sv
package pstp_pkg;

  // The tile size must be a power of two so that tile index and offset are bit fields.
  localparam int unsigned TileSize  = 32;
  localparam int unsigned TileBits  = $clog2(TileSize);
  localparam int unsigned CoordW    = 12;
  localparam int unsigned ScrollW   = 5;
  localparam int unsigned SyW       = CoordW + 1;
  localparam int unsigned TxW       = CoordW - TileBits;
  localparam int unsigned TyW       = SyW - TileBits;
  localparam int unsigned NumStages = 5;
  localparam int unsigned MortarW   = 2;

  localparam logic [TileBits-1:0] HalfTile   = TileBits'(TileSize / 2);
  localparam logic [TileBits-1:0] MortarEdge = TileBits'(MortarW);

  localparam logic [31:0] HashTx  = 32'd374761393;
  localparam logic [31:0] HashTy  = 32'd668265263;
  localparam logic [31:0] HashMix = 32'd1274126177;
  localparam logic [31:0] HashPx  = 32'd2654435761;
  localparam logic [31:0] HashPy  = 32'd2246822519;

  localparam logic [5:0] BaseLevel  = 6'd28;
  localparam logic [7:0] MortarAddR = 8'd15;
  localparam logic [7:0] MortarAddG = 8'd12;
  localparam logic [7:0] MortarAddB = 8'd10;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // Since 8 is 1 modulo 7, the sum of the octal digits has the same residue.
  function automatic logic [6:0] oct_digit_sum(logic [31:0] v);
    logic [32:0] w;
    logic [6:0]  s;
    w = {1'b0, v};
    s = '0;
    for (int i = 0; i < 11; i++) begin
      s = s + 7'(w[3*i +: 3]);
    end
    return s;
  endfunction

  // Since 16 is 1 modulo 5, the sum of the hex digits has the same residue.
  function automatic logic [6:0] nib_digit_sum(logic [29:0] v);
    logic [31:0] w;
    logic [6:0]  s;
    w = {2'b00, v};
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 7'(w[4*i +: 4]);
    end
    return s;
  endfunction

  function automatic logic [2:0] mod7_small(logic [6:0] v);
    logic [3:0] s;
    s = 4'(v[2:0]) + 4'(v[5:3]) + 4'(v[6]);
    if (s >= 4'd14) begin
      s = s - 4'd14;
    end else if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  function automatic logic [2:0] mod5_small(logic [6:0] v);
    logic [4:0] s;
    s = 5'(v[3:0]) + 5'(v[6:4]);
    if (s >= 5'd20) begin
      s = s - 5'd20;
    end else if (s >= 5'd15) begin
      s = s - 5'd15;
    end else if (s >= 5'd10) begin
      s = s - 5'd10;
    end else if (s >= 5'd5) begin
      s = s - 5'd5;
    end
    return s[2:0];
  endfunction

  function automatic logic [7:0] clamp8(logic signed [9:0] v);
    logic [7:0] r;
    if (v < 10'sd0) begin
      r = 8'd0;
    end else if (v > 10'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

endpackage

// File: sv/pstp_pipe_ctl.sv
module pstp_pipe_ctl #(
  parameter int unsigned STAGES = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_ready_i,
  output logic              in_ready_o,
  output logic [STAGES-1:0] stage_en_o,
  output logic [STAGES-1:0] stage_valid_o
);

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_d;
  logic [STAGES-1:0] en;

  // A stage loads when it is empty or when its content moves on.
  always_comb begin
    en[STAGES-1] = !valid_q[STAGES-1] || out_ready_i;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
    valid_d = valid_q;
    for (int k = 0; k < STAGES; k++) begin
      if (en[k]) begin
        valid_d[k] = (k == 0) ? in_valid_i : valid_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o    = en[0];
  assign stage_en_o    = en;
  assign stage_valid_o = valid_q;

endmodule

// File: sv/procedural_stone_tile_pixel_core.sv
// Throughput: one pixel per cycle while m_axis_tready is high; the five register stages
// advance independently, so a bubble is filled while the output is stalled.
// Reset: rst_ni clears all stage valid bits and the scroll offset register to zero;
// data registers are not reset.
module procedural_stone_tile_pixel_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pstp_pkg::ScrollW-1:0]   cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // pixel_x[11:0], pixel_y[23:12]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

  import pstp_pkg::*;

  logic [ScrollW-1:0]   scroll_q;
  logic [NumStages-1:0] en;
  logic [NumStages-1:0] vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_q <= '0;
    end else if (cfg_we_i) begin
      scroll_q <= cfg_wdata_i;
    end
  end

  pstp_pipe_ctl #(
    .STAGES(NumStages)
  ) u_ctl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .in_ready_o   (s_axis_tready),
    .stage_en_o   (en),
    .stage_valid_o(vld)
  );

  // Stage 1: tile split, mortar decision and hash products.
  logic [CoordW-1:0]   px;
  logic [CoordW-1:0]   py;
  logic [SyW-1:0]      sy;
  logic [TxW-1:0]      tx;
  logic [TyW-1:0]      ty;
  logic [TileBits-1:0] fx;
  logic [TileBits-1:0] fy;
  logic [TileBits-1:0] fx_shift;
  logic                mortar;

  always_comb begin
    px       = s_axis_tdata[CoordW-1:0];
    py       = s_axis_tdata[2*CoordW-1:CoordW];
    sy       = SyW'(py) + SyW'(scroll_q);
    tx       = px[CoordW-1:TileBits];
    ty       = sy[SyW-1:TileBits];
    fx       = px[TileBits-1:0];
    fy       = sy[TileBits-1:0];
    fx_shift = fx + HalfTile;
    mortar   = (fx < MortarEdge) || (fy < MortarEdge);
    if (ty[0] && (fx < MortarEdge)) begin
      mortar = (fx_shift < MortarEdge) || (fy < MortarEdge);
    end
  end

  logic [31:0] s1_tx_q, s1_ty_q, s1_px_q, s1_py_q;
  logic        s1_mortar_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_tx_q     <= 32'(tx) * HashTx;
      s1_ty_q     <= 32'(ty) * HashTy;
      s1_px_q     <= 32'(px) * HashPx;
      s1_py_q     <= 32'(py) * HashPy;
      s1_mortar_q <= mortar;
    end
  end

  // Stage 2: hash sums and first xor-shift.
  logic [31:0] h0, p0;
  logic [31:0] s2_h_q, s2_p_q;
  logic        s2_mortar_q;

  assign h0 = s1_tx_q + s1_ty_q;
  assign p0 = s1_px_q + s1_py_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_h_q      <= h0 ^ (h0 >> 13);
      s2_p_q      <= p0 ^ (p0 >> 16);
      s2_mortar_q <= s1_mortar_q;
    end
  end

  // Stage 3: tile mix multiply and pixel digit sum.
  logic [31:0] s3_h_q;
  logic [6:0]  s3_psum_q;
  logic        s3_mortar_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_h_q      <= s2_h_q * HashMix;
      s3_psum_q   <= oct_digit_sum(s2_p_q);
      s3_mortar_q <= s2_mortar_q;
    end
  end

  // Stage 4: final tile xor-shift with digit sum, pixel noise residue.
  logic [31:0] h2;
  logic [6:0]  s4_hsum_q;
  logic [1:0]  s4_hlo_q;
  logic [2:0]  s4_noise_q;
  logic        s4_mortar_q;

  assign h2 = s3_h_q ^ (s3_h_q >> 16);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_hsum_q   <= nib_digit_sum(h2[31:2]);
      s4_hlo_q    <= h2[1:0];
      s4_noise_q  <= mod7_small(s3_psum_q);
      s4_mortar_q <= s3_mortar_q;
    end
  end

  // Stage 5: base brightness and channel colors.
  logic [4:0]        rem20;
  logic [5:0]        base;
  logic signed [9:0] nv;
  rgb_t              rgb_d;
  rgb_t              rgb_q;

  always_comb begin
    rem20 = 5'({mod5_small(s4_hsum_q), 2'b00}) + 5'(s4_hlo_q);
    base  = BaseLevel + 6'(rem20);
    nv    = signed'(10'(base) + 10'(s4_noise_q)) - 10'sd3;
    if (s4_mortar_q) begin
      rgb_d.red   = 8'(base) + MortarAddR;
      rgb_d.green = 8'(base) + MortarAddG;
      rgb_d.blue  = 8'(base) + MortarAddB;
    end else begin
      rgb_d.red   = clamp8(nv);
      rgb_d.green = clamp8(nv - 10'sd2);
      rgb_d.blue  = clamp8(nv - 10'sd4);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      rgb_q <= rgb_d;
    end
  end

  assign m_axis_tvalid = vld[NumStages-1];
  assign m_axis_tdata  = rgb_q;

endmodule

// File: sv/pstp_checker.sv
module pstp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  logic [7:0] red, green, blue;

  assign red   = m_axis_tdata[7:0];
  assign green = m_axis_tdata[15:8];
  assign blue  = m_axis_tdata[23:16];

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("output valid while in reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transaction changed");

  a_empty_ready: assert property (@(posedge clk_i) !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the pipeline output is empty");

  a_channel_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (red >= 8'd25) && (red <= 8'd62) &&
      (((green == red - 8'd3) && (blue == red - 8'd5)) ||
       ((green == red - 8'd2) && (blue == red - 8'd4))))
    else $error("output color outside the stone palette");

endmodule

bind procedural_stone_tile_pixel_core pstp_checker u_pstp_checker (.*);
